[sv/piecewise_poly_c1_eval_assert.svh]
// Assertion macros for the piecewise polynomial evaluator.
// Included by the top level; no other dependencies.
`ifndef PIECEWISE_POLY_C1_EVAL_ASSERT_SVH
`define PIECEWISE_POLY_C1_EVAL_ASSERT_SVH
`ifndef SYNTHESIS
`define PPE_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
`define PPE_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
`else
`define PPE_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define PPE_ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif
`endif

[sv/ppe_pkg.sv]
// Package for the piecewise polynomial evaluator: sizes, codes, helpers.
// No dependencies.
`timescale 1ns / 1ps
package ppe_pkg;
  localparam int MAX_SEGMENTS = 4;
  localparam int MAX_ORDER = 3;
  localparam int FREE_DEPTH = 16;
  localparam int COEF_PER_SEG = MAX_ORDER + 1;
  localparam int SEG_DEPTH = MAX_SEGMENTS * COEF_PER_SEG;
  localparam int SEG_W = $clog2(MAX_SEGMENTS);
  localparam int BND_W = $clog2(MAX_SEGMENTS + 1);
  localparam int ORD_W = $clog2(MAX_ORDER + 1);
  localparam int FREE_W = $clog2(FREE_DEPTH);
  localparam int CIDX_W = $clog2(SEG_DEPTH);
  localparam int FCNT_W = $clog2(SEG_DEPTH + FREE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_WRITE_COEF = 2'd0,
    OP_WRITE_BND  = 2'd1,
    OP_DERIVE     = 2'd2,
    OP_EVAL       = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_SEG_COUNT = 3'd0,
    REG_ORDER0    = 3'd1,
    REG_ORDER1    = 3'd2,
    REG_ORDER2    = 3'd3,
    REG_ORDER3    = 3'd4
  } reg_t;

  typedef struct packed {
    logic signed [31:0] acc;
    logic signed [18:0] h;
    logic signed [31:0] add;
  } mac_req_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               clip;
  } mac_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v,
                                               output logic clip);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    clip = 1'b0;
    if (v > hi) begin
      clip = 1'b1;
      return 32'sh7fffffff;
    end else if (v < lo) begin
      clip = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction
endpackage

[sv/ppe_mac.sv]
// Shared registered multiply-add unit: sat32((acc*h >>> 16) + add).
// Depends on ppe_pkg.
`timescale 1ns / 1ps
module ppe_mac (
  input  logic               clk,
  input  ppe_pkg::mac_req_t  req,
  output ppe_pkg::mac_rsp_t  rsp
);
  import ppe_pkg::*;
  logic signed [50:0] prod_r;
  logic signed [31:0] add_r;
  logic signed [63:0] sum;
  logic               clip;
  logic signed [31:0] val;

  always_ff @(posedge clk) begin
    prod_r <= 51'(req.acc) * 51'(req.h);
    add_r  <= req.add;
  end

  always_comb begin
    sum = 64'(prod_r >>> 16) + 64'(add_r);
    val = sat32(sum, clip);
    rsp.value = val;
    rsp.clip  = clip;
  end
endmodule

[sv/ppe_seq.sv]
// Sequencer: table storage, derive and evaluate walks over the shared MAC.
// Depends on ppe_pkg and ppe_mac.
`timescale 1ns / 1ps
module ppe_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  ppe_pkg::op_t                op,
  input  logic [3:0]                  slot,
  input  logic signed [31:0]          wval,
  input  logic signed [17:0]          xarg,
  input  logic [2:0]                  seg_count,
  input  logic [4*ppe_pkg::ORD_W-1:0] orders,
  output logic                        busy,
  output logic                        done,
  output logic signed [31:0]          res_value,
  output logic                        res_noseg,
  output logic                        res_sat
);
  import ppe_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SEARCH = 7'b0000010,
    S_FILL   = 7'b0000100,
    S_ISSUE  = 7'b0001000,
    S_TAKE   = 7'b0010000,
    S_END    = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state_r;
  logic signed [31:0] free_r [FREE_DEPTH];
  logic signed [17:0] bnd_r  [MAX_SEGMENTS+1];
  logic signed [31:0] coef_r [SEG_DEPTH];

  logic               derive_r;
  logic               slope_r;
  logic [SEG_W-1:0]   seg_r;
  logic [ORD_W:0]     j_r;
  logic [FCNT_W-1:0]  fi_r;
  logic signed [31:0] acc_r;
  logic signed [18:0] h_r;
  logic               clip_r;
  logic signed [31:0] endv_r;
  logic signed [17:0] x_r;

  logic [SEG_W:0]     nseg;
  logic               last_seg;
  logic [ORD_W-1:0]   ord;
  logic [ORD_W:0]     fill_top;
  logic [CIDX_W-1:0]  base;
  logic [BND_W-1:0]   lo_idx;
  logic [BND_W-1:0]   hi_idx;
  logic signed [17:0] lo;
  logic signed [17:0] hi;
  logic               inseg;
  logic signed [31:0] c_top;
  logic signed [31:0] c_add;
  logic signed [31:0] fcoef;
  logic signed [31:0] top_s;
  logic               top_clip;
  logic signed [31:0] add_s;
  logic               add_clip;
  mac_req_t           req;
  mac_rsp_t           rsp;

  ppe_mac u_mac (.clk(clk), .req(req), .rsp(rsp));

  function automatic logic signed [31:0] scale_sat(input logic signed [31:0] c,
                                                   input logic [ORD_W:0] k,
                                                   output logic clip);
    logic signed [34:0] p;
    p = 35'sd0;
    if (k[0]) p = p + 35'(c);
    if (k[1]) p = p + (35'(c) <<< 1);
    if (k[2]) p = p + (35'(c) <<< 2);
    return sat32(64'(p), clip);
  endfunction

  always_comb begin
    if (seg_count == 3'd0) nseg = (SEG_W+1)'(1);
    else if (seg_count > 3'(MAX_SEGMENTS)) nseg = (SEG_W+1)'(MAX_SEGMENTS);
    else nseg = seg_count[SEG_W:0];
    last_seg = ((SEG_W+1)'(seg_r) + (SEG_W+1)'(1)) >= nseg;
    ord      = orders[seg_r*ORD_W +: ORD_W];
    fill_top = (seg_r != '0 && ord == '0) ? (ORD_W+1)'(1) : (ORD_W+1)'(ord);
    base     = CIDX_W'(seg_r) * CIDX_W'(COEF_PER_SEG);
    lo_idx   = BND_W'(seg_r);
    hi_idx   = BND_W'(seg_r) + BND_W'(1);
    lo       = bnd_r[lo_idx];
    hi       = bnd_r[hi_idx];
    inseg    = (x_r >= lo) && (x_r < hi);
    c_top    = coef_r[base + CIDX_W'(ord)];
    c_add    = coef_r[base + CIDX_W'(j_r) - CIDX_W'(1)];
    fcoef    = (fi_r < FCNT_W'(FREE_DEPTH)) ? free_r[fi_r[FREE_W-1:0]] : 32'sd0;
    top_s    = scale_sat(c_top, (ORD_W+1)'(ord), top_clip);
    add_s    = scale_sat(c_add, j_r - (ORD_W+1)'(1), add_clip);
    req.acc  = acc_r;
    req.h    = h_r;
    req.add  = slope_r ? add_s : c_add;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      derive_r <= 1'b0;
      slope_r <= 1'b0;
      seg_r <= '0;
      j_r <= '0;
      fi_r <= '0;
      acc_r <= '0;
      h_r <= '0;
      clip_r <= 1'b0;
      endv_r <= '0;
      x_r <= '0;
      res_value <= '0;
      res_noseg <= 1'b0;
      res_sat <= 1'b0;
      for (int i = 0; i < FREE_DEPTH; i++) free_r[i] <= '0;
      for (int i = 0; i <= MAX_SEGMENTS; i++) bnd_r[i] <= '0;
      for (int i = 0; i < SEG_DEPTH; i++) coef_r[i] <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            seg_r <= '0;
            x_r <= xarg;
            clip_r <= 1'b0;
            slope_r <= 1'b0;
            derive_r <= (op == OP_DERIVE);
            unique case (op)
              OP_WRITE_COEF: begin
                if (32'(slot) < FREE_DEPTH) free_r[slot[FREE_W-1:0]] <= wval;
              end
              OP_WRITE_BND: begin
                if (32'(slot) < MAX_SEGMENTS + 1) bnd_r[slot[BND_W-1:0]] <= wval[17:0];
              end
              OP_DERIVE: begin
                for (int i = 0; i < SEG_DEPTH; i++) coef_r[i] <= '0;
                fi_r <= '0;
                j_r <= '0;
                state_r <= S_FILL;
              end
              OP_EVAL: state_r <= S_SEARCH;
              default: ;
            endcase
          end
        end
        S_SEARCH: begin
          if (inseg) begin
            h_r <= 19'(x_r) - 19'(lo);
            j_r <= (ORD_W+1)'(ord);
            acc_r <= c_top;
            state_r <= (ord == '0) ? S_END : S_ISSUE;
          end else if (last_seg) begin
            res_value <= '0;
            res_noseg <= 1'b1;
            res_sat <= 1'b0;
            state_r <= S_DONE;
          end else begin
            seg_r <= seg_r + SEG_W'(1);
          end
        end
        S_FILL: begin
          if (j_r > fill_top) begin
            h_r <= 19'(hi) - 19'(lo);
            j_r <= (ORD_W+1)'(ord);
            acc_r <= c_top;
            slope_r <= 1'b0;
            state_r <= (ord == '0) ? S_END : S_ISSUE;
          end else begin
            if (seg_r == '0 || j_r >= (ORD_W+1)'(2)) begin
              coef_r[base + CIDX_W'(j_r)] <= fcoef;
              fi_r <= fi_r + FCNT_W'(1);
            end else if (j_r == '0) begin
              coef_r[base] <= endv_r;
            end else begin
              coef_r[base + CIDX_W'(1)] <= acc_r;
            end
            j_r <= j_r + (ORD_W+1)'(1);
          end
        end
        S_ISSUE: begin
          if (slope_r) clip_r <= clip_r | add_clip;
          state_r <= S_TAKE;
        end
        S_TAKE: begin
          acc_r <= rsp.value;
          clip_r <= clip_r | rsp.clip;
          j_r <= j_r - (ORD_W+1)'(1);
          if (j_r == (slope_r ? (ORD_W+1)'(2) : (ORD_W+1)'(1))) state_r <= S_END;
          else state_r <= S_ISSUE;
        end
        S_END: begin
          if (!derive_r) begin
            res_value <= acc_r;
            res_noseg <= 1'b0;
            res_sat <= clip_r;
            state_r <= S_DONE;
          end else if (!slope_r) begin
            endv_r <= acc_r;
            slope_r <= 1'b1;
            j_r <= (ORD_W+1)'(ord);
            acc_r <= (ord == '0) ? 32'sd0 : top_s;
            clip_r <= clip_r | top_clip;
            state_r <= (ord <= ORD_W'(1)) ? S_END : S_ISSUE;
          end else if (last_seg) begin
            state_r <= S_DONE;
          end else begin
            seg_r <= seg_r + SEG_W'(1);
            slope_r <= 1'b0;
            j_r <= '0;
            state_r <= S_FILL;
          end
        end
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE) && !derive_r;
endmodule

[sv/piecewise_poly_c1_eval.sv]
// Piecewise polynomial evaluator with C1 joins, Q12.20 Horner on one shared MAC.
// Evaluate searches the segments in order, then runs Horner on the matching one; derive
// fills and walks each configured segment in turn. One beat at a time: the next input beat
// is taken in the cycle after the result beat leaves; writes and derives give no result beat.
// Reset (synchronous, rst_n low): registers to 3, all tables cleared to zero.
`timescale 1ns / 1ps
`include "piecewise_poly_c1_eval_assert.svh"
module piecewise_poly_c1_eval (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic [3:0]         in_slot,
  input  logic signed [31:0] in_write_value,
  input  logic signed [17:0] in_x_arg,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_response,
  output logic               out_no_segment,
  output logic               out_saturated,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ppe_pkg::*;
  logic [2:0] seg_count_r;
  logic [ORD_W-1:0] ord_r [4];
  logic busy, done;
  logic signed [31:0] rv;
  logic rn, rs;
  logic [2:0] ridx;
  logic noseg_ok;

  assign pready = 1'b1;
  assign ridx = paddr[4:2];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_count_r <= 3'd3;
      for (int i = 0; i < 4; i++) ord_r[i] <= ORD_W'(3);
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_SEG_COUNT: seg_count_r <= pwdata[2:0];
        REG_ORDER0: ord_r[0] <= pwdata[ORD_W-1:0];
        REG_ORDER1: ord_r[1] <= pwdata[ORD_W-1:0];
        REG_ORDER2: ord_r[2] <= pwdata[ORD_W-1:0];
        REG_ORDER3: ord_r[3] <= pwdata[ORD_W-1:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (ridx)
      REG_SEG_COUNT: prdata = 32'(seg_count_r);
      REG_ORDER0: prdata = 32'(ord_r[0]);
      REG_ORDER1: prdata = 32'(ord_r[1]);
      REG_ORDER2: prdata = 32'(ord_r[2]);
      REG_ORDER3: prdata = 32'(ord_r[3]);
      default: prdata = '0;
    endcase
  end

  assign in_ready = !busy && !out_valid;

  ppe_seq u_seq (
    .clk(clk), .rst_n(rst_n), .start(in_valid && in_ready),
    .op(op_t'(in_opcode)), .slot(in_slot), .wval(in_write_value), .xarg(in_x_arg),
    .seg_count(seg_count_r), .orders({ord_r[3], ord_r[2], ord_r[1], ord_r[0]}),
    .busy(busy), .done(done), .res_value(rv), .res_noseg(rn), .res_sat(rs)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (done) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (done) begin
      out_response <= rv;
      out_no_segment <= rn;
      out_saturated <= rs;
    end
  end

  assign noseg_ok = (out_response == 32'sd0) && !out_saturated;

  `PPE_ASSERT_IMP(a_noseg_zero, clk, rst_n, out_valid && out_no_segment, noseg_ok)
  `PPE_ASSERT_IMP(a_no_accept_busy, clk, rst_n, busy, !in_ready)
  `PPE_ASSERT_NXT(a_done_shows, clk, rst_n, done, out_valid)
endmodule
